// ===== rtl/stb_pkg.sv =====
// Shared types and constants for the sprite tile binning unit.
// Used by every module of the block; depends on nothing.
package stb_pkg;

  // Default grid geometry and slot capacity.
  localparam int GRID_COLUMNS_DEF = 12;
  localparam int GRID_ROWS_DEF    = 14;
  localparam int TILE_SHIFT_DEF   = 5;
  localparam int MAX_SLOTS_DEF    = 16;

  // Field widths.
  localparam int COORD_W  = 9;
  localparam int SUM_W    = COORD_W + 1;
  localparam int TYPE_W   = 4;
  localparam int SIZE_W   = 6;
  localparam int ROT_W    = 9;
  localparam int GRID_W   = 4;
  localparam int TILE_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int WORD_W   = 32;
  localparam int RESULT_W = 4;

  // At most this many placements come from one entry.
  localparam int RESULT_LIMIT = 9;

  // Configuration port.
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int SLOTS_RESET = 16;
  localparam logic [APB_ADDR_W-3:0] REG_SLOTS_PER_TILE = '0;

  // Input command codes.
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_BIN   = 1'b1;

  // Job queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_CLEAR,
    OP_BIN
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [GRID_W-1:0] col_first;
    logic [GRID_W-1:0] col_last;
    logic [GRID_W-1:0] row_first;
    logic [GRID_W-1:0] row_last;
    logic [WORD_W-1:0] word;
  } bin_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_FLUSH
  } back_state_t;

endpackage

// ===== rtl/sprite_tile_binning_unit.sv =====
// Sprite tile binning unit: input channel, result channel and a register port.
// Each command enters through the input channel and is classified by the front
// end; clear commands and live on-grid bin commands pass a two-entry job queue.
// The back end walks the covered tiles column by column, rows within a column,
// and handles each tile in BK_READ, which reads the fill counter memory, and
// BK_CHECK, which compares it with slots_per_tile capped at MAX_SLOTS and
// writes it back. That single counter port sets the rate. A clear resets all
// counters at once. Each placement is held one step so the last one can be
// marked. Dead or off-grid entries are consumed by the front end and give
// nothing. Up to two jobs wait in the queue, so input is accepted while the
// back end is busy or the result register is stalled by out_stall; a stalled
// result holds and the back end waits on it. Reset empties the queue, drops
// pending results, zeroes all tile counters and sets slots_per_tile to 16.
// Register map: slots_per_tile at byte address 0, five bits.
module sprite_tile_binning_unit import stb_pkg::*; #(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int TILE_SHIFT   = TILE_SHIFT_DEF,
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [COORD_W-1:0]    pos_x,
  input  logic [COORD_W-1:0]    pos_y,
  input  logic [TYPE_W-1:0]     sprite_type,
  input  logic                  entry_valid,
  input  logic [SIZE_W-1:0]     sprite_width,
  input  logic [SIZE_W-1:0]     sprite_height,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TILE_W-1:0]     tile_index,
  output logic [SLOT_W-1:0]     slot_index,
  output logic [WORD_W-1:0]     entry_word,
  output logic                  last_placement
);

  localparam int TILE_COUNT = GRID_COLUMNS * GRID_ROWS;

  logic [COUNT_W-1:0] slots_per_tile;
  logic               reg_hit;
  logic               reg_write;
  logic               push;
  bin_job_t           push_job;
  logic               queue_full;
  logic               job_valid;
  logic               job_pop;
  bin_job_t           job;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_SLOTS_PER_TILE);
  assign reg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? APB_DATA_W'(slots_per_tile) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_tile <= COUNT_W'(SLOTS_RESET);
    end else if (reg_write) begin
      slots_per_tile <= pwdata[COUNT_W-1:0];
    end
  end

  stb_front #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .TILE_SHIFT   (TILE_SHIFT)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .sprite_type   (sprite_type),
    .entry_valid   (entry_valid),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .queue_full    (queue_full),
    .push          (push),
    .push_job      (push_job)
  );

  stb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (job_pop),
    .not_empty (job_valid),
    .pop_job   (job)
  );

  stb_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .MAX_SLOTS    (MAX_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job            (job),
    .job_pop        (job_pop),
    .slots_per_tile (slots_per_tile),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tile_index     (tile_index),
    .slot_index     (slot_index),
    .entry_word     (entry_word),
    .last_placement (last_placement)
  );

`ifndef SYNTHESIS
  // Every placement targets a tile inside the grid.
  a_tile_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((TILE_W + 1)'(tile_index) < (TILE_W + 1)'(TILE_COUNT)))
    else $error("placement outside the tile grid");

  // A tile never hands out a slot at or beyond the configured capacity.
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (COUNT_W'(slot_index) < slots_per_tile))
    else $error("slot index beyond slots_per_tile");

  // Reset leaves the result register empty and the input open.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not quiet after reset");
`endif

endmodule

// ===== rtl/stb_front.sv =====
// Front end of the binning unit: accepts commands and turns them into jobs.
// Depends on stb_pkg; feeds stb_queue.
module stb_front import stb_pkg::*; #(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int TILE_SHIFT   = TILE_SHIFT_DEF
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [TYPE_W-1:0] sprite_type,
  input  logic              entry_valid,
  input  logic [SIZE_W-1:0] sprite_width,
  input  logic [SIZE_W-1:0] sprite_height,
  input  logic              queue_full,
  output logic              push,
  output bin_job_t          push_job
);

  logic [SUM_W-1:0]   x_end;
  logic [SUM_W-1:0]   y_end;
  logic [COORD_W-1:0] col_first_w;
  logic [COORD_W-1:0] row_first_w;
  logic [SUM_W-1:0]   col_last_w;
  logic [SUM_W-1:0]   row_last_w;
  logic               on_grid;
  logic               keep;

  assign x_end       = SUM_W'(pos_x) + SUM_W'(sprite_width);
  assign y_end       = SUM_W'(pos_y) + SUM_W'(sprite_height);
  assign col_first_w = pos_x >> TILE_SHIFT;
  assign row_first_w = pos_y >> TILE_SHIFT;
  assign col_last_w  = x_end >> TILE_SHIFT;
  assign row_last_w  = y_end >> TILE_SHIFT;

  // A sprite whose first column or row lies past the grid covers no tile.
  assign on_grid = (col_first_w < COORD_W'(GRID_COLUMNS)) &&
                   (row_first_w < COORD_W'(GRID_ROWS));

  // Dead or off-grid entries are consumed here and never reach the back end.
  assign keep     = (command == CMD_CLEAR) || (entry_valid && on_grid);
  assign in_stall = queue_full;
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    push_job.op        = (command == CMD_CLEAR) ? OP_CLEAR : OP_BIN;
    push_job.col_first = col_first_w[GRID_W-1:0];
    push_job.row_first = row_first_w[GRID_W-1:0];
    push_job.col_last  = (col_last_w > SUM_W'(GRID_COLUMNS - 1)) ?
                         GRID_W'(GRID_COLUMNS - 1) : col_last_w[GRID_W-1:0];
    push_job.row_last  = (row_last_w > SUM_W'(GRID_ROWS - 1)) ?
                         GRID_W'(GRID_ROWS - 1) : row_last_w[GRID_W-1:0];
    push_job.word      = {1'b1, sprite_type, {ROT_W{1'b0}}, pos_y, pos_x};
  end

endmodule

// ===== rtl/stb_queue.sv =====
// Short job queue that decouples the front end from the tile sequencer.
// Depends on stb_pkg.
module stb_queue import stb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bin_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output bin_job_t pop_job
);

  bin_job_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/stb_back.sv =====
// Back end of the binning unit: walks the tiles of each job, updates the
// per-tile fill counters and drives the result register. Depends on stb_pkg.
module stb_back import stb_pkg::*; #(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  bin_job_t           job,
  output logic               job_pop,
  input  logic [COUNT_W-1:0] slots_per_tile,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TILE_W-1:0]  tile_index,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [WORD_W-1:0]  entry_word,
  output logic               last_placement
);

  localparam int TILE_COUNT = GRID_COLUMNS * GRID_ROWS;
  localparam int TILE_AW    = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;

  back_state_t state, state_next;

  // Fill counters; a counter whose live bit is clear reads as zero.
  logic [COUNT_W-1:0]    cnt_mem [TILE_COUNT];
  logic [TILE_COUNT-1:0] cnt_live;

  logic [GRID_W-1:0]   col;
  logic [GRID_W-1:0]   row;
  logic [GRID_W-1:0]   row_first;
  logic [GRID_W-1:0]   col_last;
  logic [GRID_W-1:0]   row_last;
  logic [WORD_W-1:0]   word;
  logic [RESULT_W-1:0] placed;
  logic [COUNT_W-1:0]  rd_count;
  logic                rd_live;

  // One placement is held back until we know whether it is the entry's last.
  logic                pend_valid;
  logic [TILE_W-1:0]   pend_tile;
  logic [SLOT_W-1:0]   pend_slot;

  logic [TILE_W-1:0]   tile_cur;
  logic [TILE_AW-1:0]  addr;
  logic [COUNT_W-1:0]  limit;
  logic [COUNT_W-1:0]  count_now;
  logic                has_room;
  logic                out_free;
  logic                can_place;
  logic                last_tile;
  logic                hit_limit;
  logic                mem_we;
  logic                advance;
  logic                emit_prev;
  logic                emit_last;
  logic                clear_all;

  assign tile_cur  = TILE_W'(row * GRID_COLUMNS) + TILE_W'(col);
  assign addr      = tile_cur[TILE_AW-1:0];
  assign limit     = (slots_per_tile > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                            : slots_per_tile;
  assign count_now = rd_live ? rd_count : '0;
  assign has_room  = count_now < limit;
  assign out_free  = !out_valid || !out_stall;
  assign can_place = !pend_valid || out_free;
  assign last_tile = (col == col_last) && (row == row_last);
  assign hit_limit = (placed == RESULT_W'(RESULT_LIMIT - 1));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (job_valid && job.op == OP_BIN) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        state_next = BK_CHECK;
      end
      BK_CHECK: begin
        if (has_room && !can_place) begin
          state_next = BK_CHECK;
        end else if (last_tile || (has_room && hit_limit)) begin
          state_next = BK_FLUSH;
        end else begin
          state_next = BK_READ;
        end
      end
      BK_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    mem_we    = 1'b0;
    advance   = 1'b0;
    emit_last = 1'b0;
    case (state)
      BK_IDLE: begin
        job_pop = job_valid;
      end
      BK_CHECK: begin
        mem_we  = has_room && can_place;
        advance = !has_room || can_place;
      end
      BK_FLUSH: begin
        emit_last = pend_valid && out_free;
      end
      default: begin
      end
    endcase
  end

  assign emit_prev = mem_we && pend_valid;
  assign clear_all = job_pop && (job.op == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[addr] <= count_now + 1'b1;
    end
    if (state == BK_READ) begin
      rd_count <= cnt_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_live <= '0;
    end else if (clear_all) begin
      cnt_live <= '0;
    end else if (mem_we) begin
      cnt_live[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ) begin
      rd_live <= cnt_live[addr];
    end
    if (job_pop) begin
      col       <= job.col_first;
      row       <= job.row_first;
      row_first <= job.row_first;
      col_last  <= job.col_last;
      row_last  <= job.row_last;
      word      <= job.word;
    end else if (advance) begin
      if (row == row_last) begin
        row <= row_first;
        col <= col + 1'b1;
      end else begin
        row <= row + 1'b1;
      end
    end
    if (mem_we) begin
      pend_tile <= tile_cur;
      pend_slot <= count_now[SLOT_W-1:0];
    end
    if (emit_prev || emit_last) begin
      tile_index     <= pend_tile;
      slot_index     <= pend_slot;
      entry_word     <= word;
      last_placement <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      placed     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (job_pop) begin
        placed <= '0;
      end else if (mem_we) begin
        placed <= placed + 1'b1;
      end
      if (mem_we) begin
        pend_valid <= 1'b1;
      end else if (emit_last) begin
        pend_valid <= 1'b0;
      end
      if (emit_prev || emit_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
